// ----- src/lcd4_pkg.sv -----
// ----------------------------------------------------------------------------
// lcd4_pkg - shared types and constants for the 4-bit character LCD sequencer
// Request and phase payloads, controller command/status, register indexes
// and fixed byte codes of the display controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd4_pkg;

	// request kinds
	localparam logic [2:0] REQ_INIT     = 3'd0;
	localparam logic [2:0] REQ_COMMAND  = 3'd1;
	localparam logic [2:0] REQ_DATA     = 3'd2;
	localparam logic [2:0] REQ_POSITION = 3'd3;
	localparam logic [2:0] REQ_CLEAR    = 3'd4;
	localparam logic [2:0] REQ_NUMBER   = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_POWER_UP_WAIT  = 3'd0;
	localparam logic [2:0] CFG_WAKEUP_WAIT    = 3'd1;
	localparam logic [2:0] CFG_SHORT_WAKEUP   = 3'd2;
	localparam logic [2:0] CFG_CLEAR_WAIT     = 3'd3;
	localparam logic [2:0] CFG_SETTLE_WAIT    = 3'd4;
	localparam logic [2:0] CFG_FUNCTION_SET   = 3'd5;
	localparam logic [2:0] CFG_DISPLAY_CTRL   = 3'd6;
	localparam logic [2:0] CFG_ENTRY_MODE     = 3'd7;

	// register reset values
	localparam logic [15:0] RST_POWER_UP_WAIT = 16'd50000;
	localparam logic [15:0] RST_WAKEUP_WAIT   = 16'd4500;
	localparam logic [15:0] RST_SHORT_WAKEUP  = 16'd150;
	localparam logic [15:0] RST_CLEAR_WAIT    = 16'd2000;
	localparam logic [15:0] RST_SETTLE_WAIT   = 16'd100;
	localparam logic [7:0]  RST_FUNCTION_SET  = 8'h28;
	localparam logic [7:0]  RST_DISPLAY_CTRL  = 8'h0C;
	localparam logic [7:0]  RST_ENTRY_MODE    = 8'h06;

	// display byte codes
	localparam logic [7:0] CLEAR_CMD    = 8'h01;
	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [6:0] LINE1_OFFSET = 7'h40;
	localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
	localparam logic [3:0] MODE4_NIBBLE = 4'h2;
	localparam logic [16:0] EDGE_HOLD_US = 17'd1;

	// sizing for the largest supported digit count (10)
	localparam int DIG_IDX_W = 4;   // holds 0..10
	localparam int NIB_W     = 5;   // nibble index, up to 20 nibbles
	localparam logic [NIB_W-1:0] INIT_NIBBLES = 5'd12;
	localparam logic [NIB_W-1:0] WAKE_NIBBLES = 5'd4;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  byte_value;
		logic        line_sel;
		logic [5:0]  column;
		logic [15:0] number_value;
		logic [2:0]  digit_count;
	} req_item_t;

	typedef struct packed {
		logic [3:0]  data_nibble;
		logic        reg_select;
		logic        enable_pin;
		logic [16:0] hold_us;
		logic        last_phase;
	} phase_item_t;

	// controller -> datapath
	typedef struct packed {
		logic                 load;     // capture request payload
		logic                 conv;     // one decimal digit step
		logic                 emit;     // load output register
		logic                 pwr;      // emit the power-up phase
		logic                 last;     // final phase of the request
		logic [NIB_W-1:0]     nib;      // nibble index within request
		logic [1:0]           phase;    // phase within nibble
		logic [DIG_IDX_W-1:0] dig;      // digit slot to write or read
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- src/lcd4_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcd4_ctrl - request sequencer
// Walks each request through digit conversion (number), the power-up phase
// (init), then the nibble/phase sequence; one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_ctrl #(
	parameter int MAX_DIGITS = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire logic [2:0]           req_type,
	input  wire logic [2:0]           digit_count,
	output lcd4_pkg::dp_cmd_t         cmd,
	input  wire lcd4_pkg::dp_status_t stat
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_PWR  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam logic [lcd4_pkg::DIG_IDX_W-1:0] DIG_MAX =
		lcd4_pkg::DIG_IDX_W'(MAX_DIGITS);

	logic [1:0]                          state_q, state_d;
	logic [2:0]                          req_q, req_d;
	logic [lcd4_pkg::NIB_W-1:0]          nib_q, nib_d;
	logic [1:0]                          ph_q, ph_d;
	logic [lcd4_pkg::DIG_IDX_W-1:0]      cnt_q, cnt_d;
	logic [lcd4_pkg::DIG_IDX_W-1:0]      dc_q, dc_d;
	logic [lcd4_pkg::DIG_IDX_W-1:0]      dc_in;
	logic [lcd4_pkg::NIB_W-1:0]          nib_total;
	logic                                accept;
	logic                                last;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	// saturate the digit count
	assign dc_in = ({1'b0, digit_count} > DIG_MAX) ? DIG_MAX : {1'b0, digit_count};

	always_comb begin
		unique case (req_q)
			lcd4_pkg::REQ_INIT:   nib_total = lcd4_pkg::INIT_NIBBLES;
			lcd4_pkg::REQ_NUMBER: nib_total = {dc_q, 1'b0};
			default:              nib_total = lcd4_pkg::NIB_W'(2);
		endcase
	end

	assign last = (nib_q == nib_total - 1'b1) && (ph_q == 2'd2);

	always_comb begin
		state_d = state_q;
		req_d   = req_q;
		nib_d   = nib_q;
		ph_d    = ph_q;
		cnt_d   = cnt_q;
		dc_d    = dc_q;

		cmd       = '0;
		cmd.nib   = nib_q;
		cmd.phase = ph_q;
		cmd.dig   = cnt_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					req_d    = req_type;
					nib_d    = '0;
					ph_d     = 2'd0;
					cnt_d    = '0;
					dc_d     = dc_in;
					priority case (1'b1)
						req_type == lcd4_pkg::REQ_INIT: state_d = ST_PWR;
						req_type == lcd4_pkg::REQ_NUMBER:
							state_d = (dc_in == '0) ? ST_IDLE : ST_CONV;
						req_type == lcd4_pkg::REQ_COMMAND || req_type == lcd4_pkg::REQ_DATA ||
						req_type == lcd4_pkg::REQ_POSITION || req_type == lcd4_pkg::REQ_CLEAR:
							state_d = ST_EMIT;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CONV: begin
				// digits come out least significant first into slot cnt
				cmd.conv = 1'b1;
				if (cnt_q == dc_q - 1'b1) begin
					state_d = ST_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_PWR: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.pwr  = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// most significant digit is read first
				cmd.dig = dc_q - 1'b1 - nib_q[lcd4_pkg::NIB_W-1:1];
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = last;
					if (ph_q == 2'd2) begin
						ph_d  = 2'd0;
						nib_d = nib_q + 1'b1;
					end else begin
						ph_d = ph_q + 1'b1;
					end
					if (last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q   <= lcd4_pkg::REQ_INIT;
			nib_q   <= '0;
			ph_q    <= 2'd0;
			cnt_q   <= '0;
			dc_q    <= '0;
		end else begin
			state_q <= state_d;
			req_q   <= req_d;
			nib_q   <= nib_d;
			ph_q    <= ph_d;
			cnt_q   <= cnt_d;
			dc_q    <= dc_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/lcd4_datapath.sv -----
// ----------------------------------------------------------------------------
// lcd4_datapath - registers, digit converter and phase builder
// Holds the configuration, the captured request, the decimal digits and
// the output register that drives the phase channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_datapath #(
	parameter int MAX_DIGITS = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [15:0]          cfg_data,
	input  wire lcd4_pkg::req_item_t  req,
	input  wire lcd4_pkg::dp_cmd_t    cmd,
	output lcd4_pkg::dp_status_t      stat,
	output lcd4_pkg::phase_item_t     phase,
	output logic                      phase_valid,
	input  wire logic                 phase_ready
);

	localparam int DI_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [15:0] RECIP10 = 16'd52429;   // 2^19 / 10, rounded up

	logic [15:0] power_up_q, wakeup_q, short_wakeup_q, clear_wait_q, settle_q;
	logic [7:0]  function_set_q, display_ctrl_q, entry_mode_q;

	logic [2:0]  req_q;
	logic [7:0]  byte_q;
	logic [15:0] num_q;
	logic [3:0]  digit_q [MAX_DIGITS];

	lcd4_pkg::phase_item_t out_q;
	logic                  out_valid_q;

	logic [7:0]  byte_in;
	logic [6:0]  addr;
	logic [31:0] prod;
	logic [15:0] quot;
	logic [15:0] rem;

	logic [lcd4_pkg::NIB_W-1:0] init_idx;
	logic [1:0]  init_byte;
	logic [7:0]  byte_sel;
	logic        hi;
	logic        wake;
	logic [3:0]  wake_val;
	logic        rs;
	logic [15:0] extra;
	logic [3:0]  nib_val;
	lcd4_pkg::phase_item_t build;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_up_q     <= lcd4_pkg::RST_POWER_UP_WAIT;
			wakeup_q       <= lcd4_pkg::RST_WAKEUP_WAIT;
			short_wakeup_q <= lcd4_pkg::RST_SHORT_WAKEUP;
			clear_wait_q   <= lcd4_pkg::RST_CLEAR_WAIT;
			settle_q       <= lcd4_pkg::RST_SETTLE_WAIT;
			function_set_q <= lcd4_pkg::RST_FUNCTION_SET;
			display_ctrl_q <= lcd4_pkg::RST_DISPLAY_CTRL;
			entry_mode_q   <= lcd4_pkg::RST_ENTRY_MODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcd4_pkg::CFG_POWER_UP_WAIT: power_up_q     <= cfg_data;
				lcd4_pkg::CFG_WAKEUP_WAIT:   wakeup_q       <= cfg_data;
				lcd4_pkg::CFG_SHORT_WAKEUP:  short_wakeup_q <= cfg_data;
				lcd4_pkg::CFG_CLEAR_WAIT:    clear_wait_q   <= cfg_data;
				lcd4_pkg::CFG_SETTLE_WAIT:   settle_q       <= cfg_data;
				lcd4_pkg::CFG_FUNCTION_SET:  function_set_q <= cfg_data[7:0];
				lcd4_pkg::CFG_DISPLAY_CTRL:  display_ctrl_q <= cfg_data[7:0];
				lcd4_pkg::CFG_ENTRY_MODE:    entry_mode_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// byte for single-byte requests; set-address sum fits in 7 bits
	assign addr = {1'b0, req.column} + (req.line_sel ? lcd4_pkg::LINE1_OFFSET : 7'h00);

	always_comb begin
		unique case (req.req_type)
			lcd4_pkg::REQ_POSITION: byte_in = {1'b1, addr};
			lcd4_pkg::REQ_CLEAR:    byte_in = lcd4_pkg::CLEAR_CMD;
			default:                byte_in = req.byte_value;
		endcase
	end

	// divide by ten via reciprocal, exact for 16-bit values
	assign prod = num_q * RECIP10;
	assign quot = 16'(prod[31:19]);
	assign rem  = num_q - ((quot << 3) + (quot << 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req.req_type;
			byte_q <= byte_in;
			num_q  <= req.number_value;
		end else if (cmd.conv) begin
			num_q <= quot;
			digit_q[cmd.dig[DI_W-1:0]] <= rem[3:0];
		end
	end

	// phase builder
	assign init_idx  = cmd.nib - lcd4_pkg::WAKE_NIBBLES;
	assign init_byte = init_idx[2:1];

	always_comb begin
		byte_sel = byte_q;
		hi       = !cmd.nib[0];
		wake     = 1'b0;
		wake_val = lcd4_pkg::WAKE_NIBBLE;
		rs       = 1'b0;
		extra    = '0;
		unique case (req_q)
			lcd4_pkg::REQ_INIT: begin
				if (cmd.nib < lcd4_pkg::WAKE_NIBBLES) begin
					wake = 1'b1;
					unique case (cmd.nib[1:0])
						2'd0, 2'd1: extra = wakeup_q;
						2'd2:       extra = short_wakeup_q;
						default: begin
							wake_val = lcd4_pkg::MODE4_NIBBLE;
							extra    = '0;
						end
					endcase
				end else begin
					hi = !init_idx[0];
					unique case (init_byte)
						2'd0:    byte_sel = function_set_q;
						2'd1:    byte_sel = display_ctrl_q;
						2'd2:    byte_sel = lcd4_pkg::CLEAR_CMD;
						default: byte_sel = entry_mode_q;
					endcase
					if (init_byte == 2'd2 && init_idx[0]) begin
						extra = clear_wait_q;
					end
				end
			end
			lcd4_pkg::REQ_DATA: rs = 1'b1;
			lcd4_pkg::REQ_CLEAR: begin
				if (cmd.nib[0]) begin
					extra = clear_wait_q;
				end
			end
			lcd4_pkg::REQ_NUMBER: begin
				rs       = 1'b1;
				byte_sel = lcd4_pkg::ASCII_ZERO + {4'h0, digit_q[cmd.dig[DI_W-1:0]]};
			end
			default: ;
		endcase

		priority if (wake) begin
			nib_val = wake_val;
		end else if (hi) begin
			nib_val = byte_sel[7:4];
		end else begin
			nib_val = byte_sel[3:0];
		end

		build.data_nibble = nib_val;
		build.reg_select  = rs;
		build.enable_pin  = (cmd.phase == 2'd1);
		build.hold_us     = (cmd.phase == 2'd2) ? (17'(settle_q) + 17'(extra))
		                                        : lcd4_pkg::EDGE_HOLD_US;
		build.last_phase  = cmd.last;

		if (cmd.pwr) begin
			build         = '0;
			build.hold_us = 17'(power_up_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (phase_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= build;
		end
	end

	assign stat.out_free = !out_valid_q || phase_ready;
	assign phase_valid   = out_valid_q;
	assign phase         = out_q;

endmodule

`default_nettype wire

// ----- src/char_lcd_4bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_4bit_sequencer - host side of a 4-bit character LCD bus
// Expands init, command, data, position, clear and number requests into
// timed pin phases, high nibble first, three phases per nibble.
//
//   channel  | signals                               | role
//   ---------+---------------------------------------+----------------------
//   req      | req_valid, req_ready, req             | request in
//   phase    | phase_valid, phase_ready, phase       | pin phase out
//   cfg      | cfg_we, cfg_index, cfg_data           | register write
//
// A request is taken only while the sequencer is idle. Each phase passes
// through the output register; a number request first converts its digits
// with the reciprocal divide-by-ten step. A stall on phase_ready holds the
// sequencer; reset restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_4bit_sequencer #(
	parameter int MAX_DIGITS = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire lcd4_pkg::req_item_t   req,
	output logic                       phase_valid,
	input  wire logic                  phase_ready,
	output lcd4_pkg::phase_item_t      phase,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [15:0]           cfg_data
);

	lcd4_pkg::dp_cmd_t    cmd;
	lcd4_pkg::dp_status_t stat;

	lcd4_ctrl #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req.req_type),
		.digit_count (req.digit_count),
		.cmd         (cmd),
		.stat        (stat)
	);

	lcd4_datapath #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req),
		.cmd         (cmd),
		.stat        (stat),
		.phase       (phase),
		.phase_valid (phase_valid),
		.phase_ready (phase_ready)
	);

`ifndef ASSERT_OFF
	// a phase is only loaded when the output register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("phase loaded over a pending transaction");

	// no phase is loaded and no digit converted while a request may be taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !cmd.emit && !cmd.conv)
		else $error("datapath active while idle");

	// the final phase returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.last |=> req_ready)
		else $error("sequencer not idle after final phase");
`endif

endmodule

`default_nettype wire
